[rtl/core/glc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the glyph lookup block.
// No dependencies; used by every module under rtl/core.
package glc_pkg;

  localparam int TABLE_DEPTH = 32768;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CODE_W      = 21;
  localparam int CACHE_WAYS  = 8;
  localparam int WAY_W       = $clog2(CACHE_WAYS);
  localparam int AGE_W       = 32;
  localparam int GLYPH_BYTES = 128;
  localparam int OFF_W       = 32;
  localparam int TOTAL_W     = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2
  } glc_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_TOTAL = 1'b0,
    CFG_BITMAP_BASE = 1'b1
  } glc_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PROBE,
    ST_CMP,
    ST_TAG,
    ST_SCAN,
    ST_FILL,
    ST_RESULT
  } glc_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  table_slot;
    logic [CODE_W-1:0] char_code;
  } glc_req_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  glyph_position;
    logic              hit;
    logic [WAY_W-1:0]  way;
    logic              fetch;
    logic [OFF_W-1:0]  fetch_offset;
  } glc_rsp_t;

  typedef struct packed {
    logic capture;
    logic mem_write;
    logic cache_clear;
    logic mem_read;
    logic set_found;
    logic narrow;
    logic hit_update;
    logic fill_invalid;
    logic scan_start;
    logic scan_step;
    logic fill_victim;
    logic out_load;
  } glc_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              range_empty;
    logic              probe_eq;
    logic              tag_hit;
    logic              any_invalid;
    logic              scan_last;
    logic              out_free;
  } glc_status_t;

endpackage

[rtl/core/glyph_lookup_lru_cache.sv]
`timescale 1ns / 1ps
// Top level of the glyph lookup block: sequencer plus datapath.
// Depends on glc_pkg, glc_ctrl and glc_dpath.
//
// One request at a time. A load, clear or unused-mode request goes from
// acceptance through the execute state straight to the result state. Each
// binary-search probe of a lookup is a table memory read, then a compare, with
// at most 16 probes for a full table. On a miss with all 8 ways valid, an age
// scan over the ways follows, one per cycle, before the fill. A new request is
// taken as soon as the previous one has reached the output register, even while
// that result is stalled.
module glyph_lookup_lru_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  glc_pkg::glc_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output glc_pkg::glc_rsp_t              out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [glc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [glc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  glc_pkg::glc_cmd_t    cmd;
  glc_pkg::glc_status_t status;

  glc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  glc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

[rtl/core/glc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the glyph lookup block: steps one request through load, clear,
// binary search, tag check, victim scan and result. Depends on glc_pkg.
module glc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  glc_pkg::glc_status_t status_i,
  output glc_pkg::glc_cmd_t    cmd_o
);

  glc_pkg::glc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      glc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = glc_pkg::ST_EXEC;
        end
      end
      glc_pkg::ST_EXEC: begin
        case (status_i.mode)
          glc_pkg::MODE_LOAD: begin
            cmd_o.mem_write = 1'b1;
            state_d         = glc_pkg::ST_RESULT;
          end
          glc_pkg::MODE_CLEAR: begin
            cmd_o.cache_clear = 1'b1;
            state_d           = glc_pkg::ST_RESULT;
          end
          glc_pkg::MODE_LOOKUP: begin
            state_d = glc_pkg::ST_PROBE;
          end
          default: begin
            state_d = glc_pkg::ST_RESULT;
          end
        endcase
      end
      glc_pkg::ST_PROBE: begin
        if (status_i.range_empty) begin
          state_d = glc_pkg::ST_RESULT;
        end else begin
          cmd_o.mem_read = 1'b1;
          state_d        = glc_pkg::ST_CMP;
        end
      end
      glc_pkg::ST_CMP: begin
        if (status_i.probe_eq) begin
          cmd_o.set_found = 1'b1;
          state_d         = glc_pkg::ST_TAG;
        end else begin
          cmd_o.narrow = 1'b1;
          state_d      = glc_pkg::ST_PROBE;
        end
      end
      glc_pkg::ST_TAG: begin
        if (status_i.tag_hit) begin
          cmd_o.hit_update = 1'b1;
          state_d          = glc_pkg::ST_RESULT;
        end else if (status_i.any_invalid) begin
          cmd_o.fill_invalid = 1'b1;
          state_d            = glc_pkg::ST_RESULT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = glc_pkg::ST_SCAN;
        end
      end
      glc_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = glc_pkg::ST_FILL;
        end
      end
      glc_pkg::ST_FILL: begin
        cmd_o.fill_victim = 1'b1;
        state_d           = glc_pkg::ST_RESULT;
      end
      glc_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = glc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = glc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/glc_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the glyph lookup block: codepoint table memory, search bounds,
// tag cache with age stamps, config registers and result register. Depends on glc_pkg.
module glc_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  glc_pkg::glc_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output glc_pkg::glc_rsp_t                   out_rsp_o,
  input  logic                                cfg_we_i,
  input  logic [glc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [glc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  glc_pkg::glc_cmd_t                   cmd_i,
  output glc_pkg::glc_status_t                status_o
);

  logic [glc_pkg::CODE_W-1:0]  code_table [glc_pkg::TABLE_DEPTH];
  logic [glc_pkg::CODE_W-1:0]  rd_q;

  logic [glc_pkg::TOTAL_W-1:0] glyph_total_q;
  logic [glc_pkg::OFF_W-1:0]   bitmap_base_q;

  glc_pkg::glc_req_t           req_q;
  glc_pkg::glc_rsp_t           res_q, out_q;
  logic                        out_valid_q;

  logic [glc_pkg::CNT_W-1:0]   lo_q, end_q, mid_q, mid, limit;

  logic [glc_pkg::CODE_W-1:0]  way_tag_q   [glc_pkg::CACHE_WAYS];
  logic [glc_pkg::AGE_W-1:0]   way_age_q   [glc_pkg::CACHE_WAYS];
  logic [glc_pkg::CACHE_WAYS-1:0] way_valid_q;
  logic [glc_pkg::AGE_W-1:0]   age_clock_q, age_next;

  logic [glc_pkg::WAY_W-1:0]   scan_cnt_q, victim_q;
  logic [glc_pkg::AGE_W-1:0]   best_q;

  logic [glc_pkg::WAY_W-1:0]   hit_way, inv_way, fill_way;
  logic                        tag_hit, any_invalid;
  logic [glc_pkg::OFF_W-1:0]   offset;

  always_comb begin
    limit = (glyph_total_q > glc_pkg::TOTAL_W'(glc_pkg::TABLE_DEPTH))
          ? glc_pkg::CNT_W'(glc_pkg::TABLE_DEPTH)
          : glc_pkg::CNT_W'(glyph_total_q);
    mid   = lo_q + ((end_q - lo_q - glc_pkg::CNT_W'(1)) >> 1);
  end

  always_comb begin
    tag_hit     = 1'b0;
    hit_way     = '0;
    any_invalid = 1'b0;
    inv_way     = '0;
    for (int w = glc_pkg::CACHE_WAYS - 1; w >= 0; w--) begin
      if (way_valid_q[w] && way_tag_q[w] == req_q.char_code) begin
        tag_hit = 1'b1;
        hit_way = glc_pkg::WAY_W'(w);
      end
    end
    for (int w = 0; w < glc_pkg::CACHE_WAYS; w++) begin
      if (!way_valid_q[w]) begin
        any_invalid = 1'b1;
        inv_way     = glc_pkg::WAY_W'(w);
      end
    end
    fill_way = cmd_i.fill_invalid ? inv_way : victim_q;
    age_next = age_clock_q + glc_pkg::AGE_W'(1);
    offset   = bitmap_base_q
             + glc_pkg::OFF_W'(res_q.glyph_position) * glc_pkg::OFF_W'(glc_pkg::GLYPH_BYTES);
  end

  always_comb begin
    status_o             = '0;
    status_o.mode        = req_q.mode;
    status_o.range_empty = (lo_q >= end_q);
    status_o.probe_eq    = (rd_q == req_q.char_code);
    status_o.tag_hit     = tag_hit;
    status_o.any_invalid = any_invalid;
    status_o.scan_last   = (scan_cnt_q == glc_pkg::WAY_W'(glc_pkg::CACHE_WAYS - 1));
    status_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      code_table[req_q.table_slot] <= req_q.char_code;
    end
    if (cmd_i.mem_read) begin
      rd_q <= code_table[mid[glc_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_total_q <= '0;
      bitmap_base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        glc_pkg::CFG_GLYPH_TOTAL: glyph_total_q <= cfg_data_i[glc_pkg::TOTAL_W-1:0];
        glc_pkg::CFG_BITMAP_BASE: bitmap_base_q <= cfg_data_i[glc_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
    end
    if (cmd_i.mem_read) begin
      mid_q <= mid;
    end
    if (cmd_i.scan_start) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_cnt_q <= scan_cnt_q + glc_pkg::WAY_W'(1);
      if (scan_cnt_q == '0 || way_age_q[scan_cnt_q] < best_q) begin
        victim_q <= scan_cnt_q;
        best_q   <= way_age_q[scan_cnt_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q  <= '0;
      end_q <= '0;
    end else if (cmd_i.capture) begin
      lo_q  <= '0;
      end_q <= limit;
    end else if (cmd_i.narrow) begin
      if (rd_q < req_q.char_code) begin
        lo_q <= mid_q + glc_pkg::CNT_W'(1);
      end else begin
        end_q <= mid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (cmd_i.capture) begin
      res_q <= '0;
    end else if (cmd_i.set_found) begin
      res_q.found          <= 1'b1;
      res_q.glyph_position <= mid_q[glc_pkg::IDX_W-1:0];
    end else if (cmd_i.hit_update) begin
      res_q.hit <= 1'b1;
      res_q.way <= hit_way;
    end else if (cmd_i.fill_invalid || cmd_i.fill_victim) begin
      res_q.way          <= fill_way;
      res_q.fetch        <= 1'b1;
      res_q.fetch_offset <= offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_valid_q <= '0;
      age_clock_q <= '0;
      for (int w = 0; w < glc_pkg::CACHE_WAYS; w++) begin
        way_tag_q[w] <= '0;
        way_age_q[w] <= '0;
      end
    end else if (cmd_i.cache_clear) begin
      way_valid_q <= '0;
      age_clock_q <= '0;
      for (int w = 0; w < glc_pkg::CACHE_WAYS; w++) begin
        way_tag_q[w] <= '0;
        way_age_q[w] <= '0;
      end
    end else if (cmd_i.hit_update) begin
      age_clock_q        <= age_next;
      way_age_q[hit_way] <= age_next;
    end else if (cmd_i.fill_invalid || cmd_i.fill_victim) begin
      age_clock_q           <= age_next;
      way_age_q[fill_way]   <= age_next;
      way_tag_q[fill_way]   <= req_q.char_code;
      way_valid_q[fill_way] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwrites a pending result");

  a_range_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.narrow |=> (end_q - lo_q) < $past(end_q - lo_q))
    else $error("search range did not shrink");

  a_fetch_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fetch) |-> (out_q.found && !out_q.hit))
    else $error("fetch without found miss");

  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_victim |=> way_valid_q[$past(victim_q)])
    else $error("victim way not marked valid");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for glyph_lookup_lru_cache: directed and random requests are checked
// against a behavioral model of the sorted table search and the LRU tag cache.
// Depends on glc_pkg and the glyph_lookup_lru_cache RTL.
module testbench;
  import glc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CODE_MAX = 21'h10FFFF;
  localparam int HOT_SLOTS = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  glc_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  glc_rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit idle_on = 1'b0;
  int errors = 0;
  int stall_left = 0;
  glc_rsp_t pending_rsp_q[$];
  int path_slots[$];

  logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
  logic [CODE_W-1:0] tag_mdl [CACHE_WAYS];
  bit way_live [CACHE_WAYS];
  logic [AGE_W-1:0] age_mdl [CACHE_WAYS];
  logic [AGE_W-1:0] age_clk;
  logic [TOTAL_W-1:0] total_mdl = '0;
  logic [OFF_W-1:0] base_mdl = '0;

  glyph_lookup_lru_cache dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_ways();
    for (int w = 0; w < CACHE_WAYS; w++) begin
      tag_mdl[w] = '0;
      way_live[w] = 1'b0;
      age_mdl[w] = '0;
    end
    age_clk = '0;
  endfunction

  function automatic glc_rsp_t predict_glyph_rsp(glc_req_t r);
    glc_rsp_t o;
    int lim;
    int lo;
    int hi;
    int mid;
    int idx;
    int victim;
    int w;
    logic [AGE_W-1:0] best;
    o = '0;
    idx = -1;
    victim = -1;
    best = '0;
    if (r.mode == MODE_LOAD) begin
      code_tbl[r.table_slot] = r.char_code;
    end else if (r.mode == MODE_CLEAR) begin
      clear_ways();
    end else if (r.mode == MODE_LOOKUP) begin
      lim = (int'(total_mdl) > TABLE_DEPTH) ? TABLE_DEPTH : int'(total_mdl);
      lo = 0;
      hi = lim - 1;
      while (lo <= hi && idx < 0) begin
        mid = lo + (hi - lo) / 2;
        if (code_tbl[mid] == r.char_code) idx = mid;
        else if (code_tbl[mid] < r.char_code) lo = mid + 1;
        else hi = mid - 1;
      end
      if (idx < 0) return o;
      o.found = 1'b1;
      o.glyph_position = idx[IDX_W-1:0];
      for (w = 0; w < CACHE_WAYS; w++) begin
        if (way_live[w] && tag_mdl[w] == r.char_code) begin
          age_clk = age_clk + 1'b1;
          age_mdl[w] = age_clk;
          o.hit = 1'b1;
          o.way = w[WAY_W-1:0];
          return o;
        end
      end
      for (w = 0; w < CACHE_WAYS; w++)
        if (!way_live[w]) victim = w;
      if (victim < 0) begin
        for (w = 0; w < CACHE_WAYS; w++) begin
          if (victim < 0 || age_mdl[w] < best) begin
            victim = w;
            best = age_mdl[w];
          end
        end
      end
      age_clk = age_clk + 1'b1;
      tag_mdl[victim] = r.char_code;
      age_mdl[victim] = age_clk;
      way_live[victim] = 1'b1;
      o.way = victim[WAY_W-1:0];
      o.fetch = 1'b1;
      o.fetch_offset = base_mdl + OFF_W'(idx * GLYPH_BYTES);
    end
    return o;
  endfunction

  function automatic int rand_span();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    return rand_span();
  endfunction

  function automatic glc_req_t make_req(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] slot,
                                        logic [CODE_W-1:0] code);
    glc_req_t r;
    r.mode = mode;
    r.table_slot = slot;
    r.char_code = code;
    return r;
  endfunction

  task automatic check_rsp(glc_rsp_t got);
    glc_rsp_t exp_rsp;
    if (pending_rsp_q.size() == 0) begin
      $error("result with no request pending: %h", got);
      errors++;
      return;
    end
    exp_rsp = pending_rsp_q.pop_front();
    if (got.found !== exp_rsp.found) begin
      $error("found: expected %0d, actual %0d", exp_rsp.found, got.found);
      errors++;
    end
    if (got.glyph_position !== exp_rsp.glyph_position) begin
      $error("glyph_position: expected %0d, actual %0d",
             exp_rsp.glyph_position, got.glyph_position);
      errors++;
    end
    if (got.hit !== exp_rsp.hit) begin
      $error("hit: expected %0d, actual %0d", exp_rsp.hit, got.hit);
      errors++;
    end
    if (got.way !== exp_rsp.way) begin
      $error("way: expected %0d, actual %0d", exp_rsp.way, got.way);
      errors++;
    end
    if (got.fetch !== exp_rsp.fetch) begin
      $error("fetch: expected %0d, actual %0d", exp_rsp.fetch, got.fetch);
      errors++;
    end
    if (got.fetch_offset !== exp_rsp.fetch_offset) begin
      $error("fetch_offset: expected %h, actual %h", exp_rsp.fetch_offset, got.fetch_offset);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) check_rsp(out_rsp);
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= rand_span();
    end
  end

  task automatic send_req(glc_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    pending_rsp_q.push_back(predict_glyph_rsp(r));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [TOTAL_W-1:0] total, logic [OFF_W-1:0] base);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GLYPH_TOTAL;
    cfg_data <= {(CFG_DATA_W - TOTAL_W)'($urandom), total};
    @(posedge clk);
    cfg_index <= CFG_BITMAP_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_we <= 1'b0;
    total_mdl = total;
    base_mdl = base;
  endtask

  task automatic fill_sorted(int count);
    int code;
    int step_max;
    step_max = (CODE_MAX - 1000) / count;
    code = $urandom_range(0, 1000);
    for (int s = 0; s < count; s++) begin
      send_req(make_req(MODE_LOAD, IDX_W'(s), CODE_W'(code)));
      code = code + $urandom_range(1, step_max);
    end
  endtask

  task automatic run_mix(int count, int hot_count);
    int lim;
    int pick;
    int k;
    int hot_slot [HOT_SLOTS];
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0] slot;
    lim = (int'(total_mdl) > TABLE_DEPTH) ? TABLE_DEPTH : int'(total_mdl);
    for (k = 0; k < HOT_SLOTS; k++) hot_slot[k] = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if (lim > 0 && pick < 60) code = code_tbl[hot_slot[$urandom_range(0, hot_count - 1)]];
        else code = CODE_W'($urandom);
        send_req(make_req(MODE_LOOKUP, IDX_W'($urandom), code));
      end else if (pick < 87) begin
        slot = (lim > 0 && $urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, lim - 1))
                                                       : IDX_W'($urandom);
        send_req(make_req(MODE_LOAD, slot, CODE_W'($urandom_range(0, CODE_MAX))));
      end else if (pick < 93) begin
        send_req(make_req(MODE_CLEAR, IDX_W'($urandom), CODE_W'($urandom)));
      end else begin
        send_req(make_req(MODE_UNUSED, IDX_W'($urandom), CODE_W'($urandom)));
      end
    end
  endtask

  task automatic run_path_mix(int count);
    int pick;
    int slot;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      slot = path_slots[$urandom_range(0, ($urandom_range(0, 1) == 0)
                                          ? 9 : path_slots.size() - 1)];
      if (pick < 80) begin
        send_req(make_req(MODE_LOOKUP, IDX_W'($urandom), code_tbl[slot]));
      end else if (pick < 88) begin
        send_req(make_req(MODE_LOOKUP, IDX_W'($urandom), CODE_W'(CODE_MAX)));
      end else if (pick < 95) begin
        send_req(make_req(MODE_CLEAR, IDX_W'($urandom), CODE_W'($urandom)));
      end else begin
        send_req(make_req(MODE_UNUSED, IDX_W'($urandom), CODE_W'($urandom)));
      end
    end
  endtask

  task automatic test_empty_table();
    idle_on = 1'b0;
    send_req(make_req(MODE_LOOKUP, '0, '0));
    send_req(make_req(MODE_UNUSED, '1, '1));
    send_req(make_req(MODE_CLEAR, '0, '0));
    drain();
  endtask

  task automatic test_directed_lru();
    logic [CODE_W-1:0] codes [10];
    codes = '{21'h000000, 21'h000001, 21'h00FF00, 21'h055555, 21'h0AAAAA,
              21'h0F0000, 21'h0FFFFF, 21'h100000, 21'h10FFFE, 21'h10FFFF};
    idle_on = 1'b1;
    for (int s = 0; s < 10; s++) send_req(make_req(MODE_LOAD, IDX_W'(s), codes[s]));
    send_req(make_req(MODE_LOAD, IDX_W'(TABLE_DEPTH - 1), '1));
    drain();
    set_config(16'd10, 32'hFFFF_FF00);
    for (int s = 0; s < 9; s++) send_req(make_req(MODE_LOOKUP, '0, codes[s]));
    send_req(make_req(MODE_LOOKUP, '1, codes[3]));
    send_req(make_req(MODE_LOOKUP, '0, 21'h000002));
    drain();
  endtask

  task automatic test_lru_phases();
    int total;
    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase % 3 != 2);
      total = (phase == 0) ? 1 : $urandom_range(2, 64);
      fill_sorted(total);
      drain();
      case (phase)
        1: set_config(TOTAL_W'(total), '0);
        2: set_config(TOTAL_W'(total), '1);
        default: set_config(TOTAL_W'(total), $urandom);
      endcase
      run_mix(80, $urandom_range(4, HOT_SLOTS));
      drain();
    end
  endtask

  // Load only the slots on the leftmost and rightmost search paths of the full
  // table, sorted by slot, and look up only codes that stay on those paths.
  task automatic test_full_table();
    int lo;
    int hi;
    int mid;
    idle_on = 1'b0;
    path_slots.delete();
    for (int side = 0; side < 2; side++) begin
      lo = 0;
      hi = TABLE_DEPTH - 1;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        path_slots.push_back(mid);
        if (side == 0) hi = mid - 1;
        else lo = mid + 1;
      end
    end
    foreach (path_slots[k])
      send_req(make_req(MODE_LOAD, IDX_W'(path_slots[k]),
                        CODE_W'(path_slots[k] * 32 + $urandom_range(0, 31))));
    drain();
    set_config(TOTAL_W'(TABLE_DEPTH), '1);
    idle_on = 1'b1;
    send_req(make_req(MODE_LOOKUP, '0, code_tbl[0]));
    send_req(make_req(MODE_LOOKUP, '0, CODE_W'(CODE_MAX)));
    run_path_mix(40);
    drain();
    set_config('1, $urandom);
    send_req(make_req(MODE_LOOKUP, '0, code_tbl[TABLE_DEPTH - 1]));
    run_path_mix(30);
    drain();
  endtask

  initial begin
    clear_ways();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_lru();
    test_lru_phases();
    test_full_table();
    idle_on = 1'b0;
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/glc_pkg.sv
rtl/core/glc_ctrl.sv
rtl/core/glc_dpath.sv
rtl/core/glyph_lookup_lru_cache.sv
dv/testbench.sv
